/* sv/lsmd_pkg.sv */
// Shared types, constants and tables of the lidar scan motion deskew block.
package lsmd_pkg;

  localparam int MAX_POINTS_DEF = 4096;

  localparam int IDX_W   = 12;
  localparam int COORD_W = 32;
  localparam int VEL_W   = 32;
  localparam int PER_W   = 20;
  localparam int NPTS_W  = 13;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LIN_VEL     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_VEL     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS      = 8'd3;

  localparam logic [PER_W-1:0] SCAN_PERIOD_RST = 20'd100000;

  localparam logic [34:0] TWO_PI_Q32  = 35'd26986075409;
  localparam logic [34:0] PI_Q32      = 35'd13493037705;
  localparam logic [34:0] HALF_PI_Q32 = 35'd6746518852;
  localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  localparam int CORDIC_STEPS = 30;
  localparam int TH_W       = 60;
  localparam int MOD_STAGES = TH_W - 35 + 1;
  localparam int DIV1_W     = 80;
  localparam int DIV2_W     = 49;
  localparam int STR_W      = 44;
  localparam int LATENCY    = 7 + DIV1_W + MOD_STAGES + CORDIC_STEPS + DIV2_W;

  typedef struct packed {
    logic [IDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] comp_x;
    logic signed [COORD_W-1:0] comp_y;
  } out_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    case (i)
      0: v = 30'd843314857;
      1: v = 30'd497837829;
      2: v = 30'd263043837;
      3: v = 30'd133525159;
      4: v = 30'd67021687;
      5: v = 30'd33543516;
      6: v = 30'd16775851;
      7: v = 30'd8388437;
      8: v = 30'd4194283;
      9: v = 30'd2097149;
      default: v = (i < 30) ? 30'(30'd1 << (30 - i)) : 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/lsmd_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a side word that travels along.
module lsmd_div #(
  parameter int NUM_W  = 80,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  acc_r  [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              p_vld;
    logic [DEN_W-1:0]  p_rem;
    logic [NUM_W-1:0]  p_acc;
    logic [DEN_W-1:0]  p_den;
    logic [SIDE_W-1:0] p_side;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic [DEN_W-1:0]  rem_nxt;
    logic [NUM_W-1:0]  acc_nxt;

    if (k == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_acc  = in_num;
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_acc  = acc_r[k-1];
      assign p_den  = den_r[k-1];
      assign p_side = side_r[k-1];
    end

    always_comb begin
      trial = {p_rem, p_acc[NUM_W-1]};
      diff  = trial - {1'b0, p_den};
      if (trial >= {1'b0, p_den}) begin
        rem_nxt = diff[DEN_W-1:0];
        acc_nxt = {p_acc[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        acc_nxt = {p_acc[NUM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      acc_r[k]  <= acc_nxt;
      den_r[k]  <= p_den;
      side_r[k] <= p_side;
    end
  end

  assign out_vld  = vld_r[NUM_W-1];
  assign out_quo  = acc_r[NUM_W-1];
  assign out_side = side_r[NUM_W-1];

endmodule

/* sv/lidar_scan_motion_deskew_top.sv */
// Top level of the lidar scan motion deskew pipeline.
// One point word is taken each cycle with start high and busy low; its compensated word appears
// on out_word, marked by out_strobe for one cycle; results cannot be held off, so the receiver
// must take every strobed word. Most stages form the 80-stage heading divider, 26-stage modulo
// reduction, 30-stage CORDIC and 49-stage offset dividers. Busy is high only in the cycle after
// reset. The user must write configuration only while no point is in flight; no check is made.
module lidar_scan_motion_deskew_top #(
  parameter int MAX_POINTS = lsmd_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  lsmd_pkg::in_t                      in_word,
  output logic                               out_strobe,
  output lsmd_pkg::out_t                     out_word,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lsmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsmd_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam longint unsigned D_MAX = 64'(MAX_POINTS) * 64'd1000000;
  localparam int D_W = $clog2(D_MAX + 1);
  localparam int TH_W = lsmd_pkg::TH_W;
  localparam int STR_W = lsmd_pkg::STR_W;
  localparam int DIV1_W = lsmd_pkg::DIV1_W;
  localparam int DIV2_W = lsmd_pkg::DIV2_W;
  localparam int MOD_N = lsmd_pkg::MOD_STAGES;
  localparam int CD_N = lsmd_pkg::CORDIC_STEPS;

  typedef struct packed {
    logic               pass;
    logic               wz;
    logic               vneg;
    logic               wneg;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } side1_t;

  typedef struct packed {
    side1_t          s;
    logic [TH_W-1:0] th;
  } mod_t;

  typedef struct packed {
    side1_t             s;
    logic [STR_W-1:0]   m;
    logic               ns;
    logic               nc;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [35:0] z;
  } cd_t;

  typedef struct packed {
    logic               pass;
    logic               wz;
    logic               xneg;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic [STR_W-1:0]   m;
  } side2_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -52'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Configuration registers.
  logic                busy_r;
  logic signed [31:0]  lin_vel_r;
  logic signed [31:0]  ang_vel_r;
  logic [lsmd_pkg::PER_W-1:0]  scan_period_r;
  logic [lsmd_pkg::NPTS_W-1:0] points_r;
  logic [lsmd_pkg::NPTS_W-1:0] n_cl;
  logic [D_W-1:0]      d_r;
  logic [31:0]         vm;
  logic [31:0]         wm;
  logic                accept;

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;
  assign accept    = start & ~busy_r;
  assign vm = lin_vel_r[31] ? (~lin_vel_r + 32'd1) : lin_vel_r;
  assign wm = ang_vel_r[31] ? (~ang_vel_r + 32'd1) : ang_vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b1;
      lin_vel_r     <= '0;
      ang_vel_r     <= '0;
      scan_period_r <= lsmd_pkg::SCAN_PERIOD_RST;
      points_r      <= '0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lsmd_pkg::REG_LIN_VEL:     lin_vel_r     <= cfg_data;
          lsmd_pkg::REG_ANG_VEL:     ang_vel_r     <= cfg_data;
          lsmd_pkg::REG_SCAN_PERIOD: scan_period_r <= cfg_data[lsmd_pkg::PER_W-1:0];
          lsmd_pkg::REG_POINTS:      points_r      <= cfg_data[lsmd_pkg::NPTS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    if (32'(points_r) > 32'(MAX_POINTS)) begin
      n_cl = lsmd_pkg::NPTS_W'(MAX_POINTS);
    end else begin
      n_cl = points_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= D_W'(64'(n_cl) * 64'd1000000);
  end

  // Stage A: flags, velocity magnitude and index times period.
  logic        a_vld_r;
  side1_t      a_s_r;
  logic [31:0] a_mag_r;
  logic [31:0] a_ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_s_r.pass <= (scan_period_r == '0) || (points_r == '0);
    a_s_r.wz   <= (ang_vel_r == '0);
    a_s_r.vneg <= lin_vel_r[31];
    a_s_r.wneg <= ang_vel_r[31];
    a_s_r.px   <= in_word.point_x;
    a_s_r.py   <= in_word.point_y;
    a_mag_r    <= (ang_vel_r == '0) ? vm : wm;
    a_ip_r     <= 32'(in_word.point_index) * 32'(scan_period_r);
  end

  // Stage B: full numerator.
  logic        b_vld_r;
  side1_t      b_s_r;
  logic [63:0] b_num_r;
  logic [DIV1_W-1:0] div1_num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_s_r   <= a_s_r;
    b_num_r <= 64'(a_mag_r) * 64'(a_ip_r);
  end

  assign div1_num = b_s_r.wz ? {16'b0, b_num_r} : {b_num_r, 16'b0};

  logic                     d1_vld;
  logic [DIV1_W-1:0]        d1_quo;
  logic [$bits(side1_t)-1:0] d1_side;

  lsmd_div #(
    .NUM_W  (DIV1_W),
    .DEN_W  (D_W),
    .SIDE_W ($bits(side1_t))
  ) u_div_head (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (b_vld_r),
    .in_num   (div1_num),
    .in_den   (d_r),
    .in_side  (b_s_r),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  // Heading reduction modulo two pi, one conditional subtraction per stage.
  logic md_vld_r [MOD_N];
  mod_t md_r     [MOD_N];

  for (genvar k = 0; k < MOD_N; k++) begin : g_mod
    localparam logic [TH_W-1:0] SUB_V = TH_W'(lsmd_pkg::TWO_PI_Q32) << (MOD_N - 1 - k);
    logic src_vld;
    mod_t src;
    mod_t nxt;

    if (k == 0) begin : g_first
      assign src_vld = d1_vld;
      assign src     = '{s: side1_t'(d1_side), th: d1_quo[TH_W-1:0]};
    end else begin : g_next
      assign src_vld = md_vld_r[k-1];
      assign src     = md_r[k-1];
    end

    always_comb begin
      nxt = src;
      if (!src.s.wz && (src.th >= SUB_V)) begin
        nxt.th = src.th - SUB_V;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        md_vld_r[k] <= 1'b0;
      end else begin
        md_vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      md_r[k] <= nxt;
    end
  end

  // Quadrant fold, then the CORDIC stages.
  logic cd_vld_r [CD_N+1];
  cd_t  cd_r     [CD_N+1];
  cd_t  fold;
  logic [34:0] fa;

  always_comb begin
    fa      = md_r[MOD_N-1].th[34:0];
    fold.s  = md_r[MOD_N-1].s;
    fold.m  = md_r[MOD_N-1].th[STR_W-1:0];
    fold.ns = 1'b0;
    fold.nc = 1'b0;
    if (fa >= lsmd_pkg::PI_Q32) begin
      fa      = fa - lsmd_pkg::PI_Q32;
      fold.ns = 1'b1;
      fold.nc = 1'b1;
    end
    if (fa > lsmd_pkg::HALF_PI_Q32) begin
      fa      = lsmd_pkg::PI_Q32 - fa;
      fold.nc = ~fold.nc;
    end
    fold.x = lsmd_pkg::GAIN_Q30;
    fold.y = '0;
    fold.z = $signed({3'b0, fa[34:2]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_vld_r[0] <= 1'b0;
    end else begin
      cd_vld_r[0] <= md_vld_r[MOD_N-1];
    end
  end

  always_ff @(posedge clk) begin
    cd_r[0] <= fold;
  end

  for (genvar i = 0; i < CD_N; i++) begin : g_cordic
    cd_t                cur;
    cd_t                nxt;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [35:0] at;

    always_comb begin
      cur = cd_r[i];
      nxt = cur;
      cx  = cur.x;
      cy  = cur.y;
      xs  = cx >>> i;
      ys  = cy >>> i;
      at  = $signed({6'b0, lsmd_pkg::atan_q30(i)});
      if (!cur.z[35]) begin
        nxt.x = cx - ys;
        nxt.y = cy + xs;
        nxt.z = cur.z - at;
      end else begin
        nxt.x = cx + ys;
        nxt.y = cy - xs;
        nxt.z = cur.z + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cd_vld_r[i+1] <= 1'b0;
      end else begin
        cd_vld_r[i+1] <= cd_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      cd_r[i+1] <= nxt;
    end
  end

  // Clamp and sign stage.
  logic               cl_vld_r;
  side1_t             cl_s_r;
  logic [STR_W-1:0]   cl_m_r;
  logic signed [31:0] cl_cs_r;
  logic signed [31:0] cl_sn_r;
  logic [30:0]        cl_snm_r;
  logic               cl_snneg_r;
  logic signed [33:0] xc;
  logic signed [33:0] yc;
  logic signed [33:0] cs_nxt;
  logic signed [33:0] sn_nxt;
  logic [33:0]        snm_nxt;

  always_comb begin
    xc = cd_r[CD_N].x;
    yc = cd_r[CD_N].y;
    if (xc > lsmd_pkg::ONE_Q30) begin
      xc = lsmd_pkg::ONE_Q30;
    end else if (xc < -lsmd_pkg::ONE_Q30) begin
      xc = -lsmd_pkg::ONE_Q30;
    end
    if (yc > lsmd_pkg::ONE_Q30) begin
      yc = lsmd_pkg::ONE_Q30;
    end else if (yc < -lsmd_pkg::ONE_Q30) begin
      yc = -lsmd_pkg::ONE_Q30;
    end
    cs_nxt  = cd_r[CD_N].nc ? -xc : xc;
    sn_nxt  = (cd_r[CD_N].ns ^ cd_r[CD_N].s.wneg) ? -yc : yc;
    snm_nxt = yc[33] ? 34'(-yc) : 34'(yc);
    if (cd_r[CD_N].s.pass || cd_r[CD_N].s.wz) begin
      cs_nxt  = lsmd_pkg::ONE_Q30;
      sn_nxt  = '0;
      snm_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_vld_r <= 1'b0;
    end else begin
      cl_vld_r <= cd_vld_r[CD_N];
    end
  end

  always_ff @(posedge clk) begin
    cl_s_r     <= cd_r[CD_N].s;
    cl_m_r     <= cd_r[CD_N].m;
    cl_cs_r    <= cs_nxt[31:0];
    cl_sn_r    <= sn_nxt[31:0];
    cl_snm_r   <= snm_nxt[30:0];
    cl_snneg_r <= sn_nxt[33];
  end

  // Multiplier stage.
  logic               mu_vld_r;
  logic               mu_pass_r;
  logic               mu_wz_r;
  logic               mu_xneg_r;
  logic               mu_yneg_r;
  logic [STR_W-1:0]   mu_m_r;
  logic signed [63:0] mu_pcx_r;
  logic signed [63:0] mu_psy_r;
  logic signed [63:0] mu_psx_r;
  logic signed [63:0] mu_pcy_r;
  logic [63:0]        mu_ps_r;
  logic [63:0]        mu_pc_r;
  logic signed [32:0] omc;

  assign omc = 33'sd1073741824 - 33'(cl_cs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_vld_r <= 1'b0;
    end else begin
      mu_vld_r <= cl_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    mu_pass_r <= cl_s_r.pass;
    mu_wz_r   <= cl_s_r.wz;
    mu_xneg_r <= cl_s_r.wz ? cl_s_r.vneg : (cl_s_r.vneg ^ cl_snneg_r ^ cl_s_r.wneg);
    mu_yneg_r <= cl_s_r.vneg ^ cl_s_r.wneg;
    mu_m_r    <= cl_m_r;
    mu_pcx_r  <= cl_cs_r * cl_s_r.px;
    mu_psy_r  <= cl_sn_r * cl_s_r.py;
    mu_psx_r  <= cl_sn_r * cl_s_r.px;
    mu_pcy_r  <= cl_cs_r * cl_s_r.py;
    mu_ps_r   <= 64'(vm) * 64'(cl_snm_r);
    mu_pc_r   <= 64'(vm) * 64'(omc[31:0]);
  end

  // Rotation sums and offset dividends.
  logic               su_vld_r;
  side2_t             su_s_r;
  logic               su_yneg_r;
  logic [DIV2_W-1:0]  su_dvs_r;
  logic [DIV2_W-1:0]  su_dvc_r;
  logic signed [63:0] rx_full;
  logic signed [63:0] ry_full;

  assign rx_full = mu_pcx_r - mu_psy_r + 64'sd536870912;
  assign ry_full = mu_psx_r + mu_pcy_r + 64'sd536870912;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_vld_r <= 1'b0;
    end else begin
      su_vld_r <= mu_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    su_s_r.pass <= mu_pass_r;
    su_s_r.wz   <= mu_wz_r;
    su_s_r.xneg <= mu_xneg_r;
    su_s_r.rx   <= rx_full[63:30];
    su_s_r.ry   <= ry_full[63:30];
    su_s_r.m    <= mu_m_r;
    su_yneg_r   <= mu_yneg_r;
    su_dvs_r    <= mu_ps_r[62:14];
    su_dvc_r    <= mu_pc_r[62:14];
  end

  logic                      ds_vld;
  logic [DIV2_W-1:0]         ds_quo;
  logic [$bits(side2_t)-1:0] ds_side;
  logic                      dc_vld;
  logic [DIV2_W-1:0]         dc_quo;
  logic                      dc_side;

  lsmd_div #(
    .NUM_W  (DIV2_W),
    .DEN_W  (32),
    .SIDE_W ($bits(side2_t))
  ) u_div_sin (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (su_vld_r),
    .in_num   (su_dvs_r),
    .in_den   (wm),
    .in_side  (su_s_r),
    .out_vld  (ds_vld),
    .out_quo  (ds_quo),
    .out_side (ds_side)
  );

  lsmd_div #(
    .NUM_W  (DIV2_W),
    .DEN_W  (32),
    .SIDE_W (1)
  ) u_div_cos (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (su_vld_r),
    .in_num   (su_dvc_r),
    .in_den   (wm),
    .in_side  (su_yneg_r),
    .out_vld  (dc_vld),
    .out_quo  (dc_quo),
    .out_side (dc_side)
  );

  // Offset add and saturation.
  side2_t             s2;
  logic [DIV2_W-1:0]  xm;
  logic [DIV2_W-1:0]  ym;
  logic signed [DIV2_W:0] xoff;
  logic signed [DIV2_W:0] yoff;
  logic signed [51:0] sx;
  logic signed [51:0] sy;
  logic               out_strobe_r;
  lsmd_pkg::out_t     out_word_r;

  always_comb begin
    s2 = side2_t'(ds_side);
    if (s2.pass) begin
      xm = '0;
    end else if (s2.wz) begin
      xm = DIV2_W'(s2.m);
    end else begin
      xm = ds_quo;
    end
    ym   = (s2.pass || s2.wz) ? '0 : dc_quo;
    xoff = $signed({1'b0, xm});
    yoff = $signed({1'b0, ym});
    if (s2.xneg) begin
      xoff = -xoff;
    end
    if (dc_side) begin
      yoff = -yoff;
    end
    sx = 52'(s2.rx) + 52'(xoff);
    sy = 52'(s2.ry) + 52'(yoff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ds_vld & dc_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r.comp_x <= sat32(sx);
    out_word_r.comp_y <= sat32(sy);
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

/* sv/lsmd_chk.sv */
// Port-level checker of the deskew top level, with its bind statement.
module lsmd_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> busy && !out_strobe)
    else $error("Strobe or ready seen straight after reset.");

  a_busy_short: assert property (@(posedge clk) disable iff (!rst_n) busy |=> !busy)
    else $error("Busy held for more than one cycle after reset.");

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(lsmd_pkg::LATENCY) out_strobe)
    else $error("Accepted word produced no result at the expected cycle.");

  a_word_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, lsmd_pkg::LATENCY))
    else $error("Result strobed without a matching accepted word.");

endmodule

bind lidar_scan_motion_deskew_top lsmd_chk u_lsmd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);

/* tb/sv/lidar_scan_motion_deskew_top_tb.sv */
// Testbench of the lidar scan motion deskew block with a bit-exact point predictor.
`timescale 1ns / 100ps
module lidar_scan_motion_deskew_top_tb;

  localparam logic [lsmd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd9;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint ONE_Q30_L = 64'sd1073741824;
  localparam longint GAIN_L = 64'sd652032874;
  localparam longint unsigned TWO_PI_L = 64'd26986075409;
  localparam longint unsigned PI_L = 64'd13493037705;
  localparam longint unsigned HALF_PI_L = 64'd6746518852;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lsmd_pkg::in_t in_word = '0;
  logic out_strobe;
  lsmd_pkg::out_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lsmd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lsmd_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  logic signed [31:0] lin_vel_q = '0;
  logic signed [31:0] ang_vel_q = '0;
  logic [lsmd_pkg::PER_W-1:0] period_q = lsmd_pkg::SCAN_PERIOD_RST;
  logic [lsmd_pkg::NPTS_W-1:0] points_q = '0;

  lsmd_pkg::out_t expected_points[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_cycles = 0;
  longint atan_tab[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  lidar_scan_motion_deskew_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic [31:0] saturate(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic void heading_sin_cos(longint unsigned a, output longint sn,
                                          output longint cs);
    bit neg_s, neg_c;
    longint x, y, z, xs, ys;
    neg_s = 0;
    neg_c = 0;
    x = GAIN_L;
    y = 0;
    if (a >= PI_L) begin
      a -= PI_L;
      neg_s = 1;
      neg_c = 1;
    end
    if (a > HALF_PI_L) begin
      a = PI_L - a;
      neg_c = ~neg_c;
    end
    z = longint'(a >> 2);
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    if (x > ONE_Q30_L) x = ONE_Q30_L;
    if (x < -ONE_Q30_L) x = -ONE_Q30_L;
    if (y > ONE_Q30_L) y = ONE_Q30_L;
    if (y < -ONE_Q30_L) y = -ONE_Q30_L;
    cs = neg_c ? -x : x;
    sn = neg_s ? -y : y;
  endfunction

  function automatic lsmd_pkg::out_t deskew_point(lsmd_pkg::in_t p);
    longint unsigned idx, n, per, d, num, th, m, wm, vm;
    longint px, py, v, w, sn, cs, xoff, yoff, rx, ry;
    lsmd_pkg::out_t r;
    idx = p.point_index;
    px = $signed(p.point_x);
    py = $signed(p.point_y);
    v = lin_vel_q;
    w = ang_vel_q;
    n = points_q;
    per = period_q;
    sn = 0;
    cs = ONE_Q30_L;
    xoff = 0;
    yoff = 0;
    if (per == 0 || n == 0) begin
      r.comp_x = p.point_x;
      r.comp_y = p.point_y;
      return r;
    end
    if (n > lsmd_pkg::MAX_POINTS_DEF) n = lsmd_pkg::MAX_POINTS_DEF;
    d = n * 64'd1000000;
    if (w == 0) begin
      m = magnitude(v) * idx * per / d;
      xoff = (v < 0) ? -longint'(m) : longint'(m);
    end else begin
      wm = magnitude(w);
      vm = magnitude(v);
      num = wm * idx * per;
      th = ((num / d) << 16) + (((num % d) << 16) / d);
      th = th % TWO_PI_L;
      heading_sin_cos(th, sn, cs);
      if (w < 0) sn = -sn;
      m = (vm * magnitude(sn) / wm) >> 14;
      xoff = (((v < 0) ^ (sn < 0) ^ (w < 0)) != 0) ? -longint'(m) : longint'(m);
      m = (vm * longint'(ONE_Q30_L - cs) / wm) >> 14;
      yoff = (((v < 0) ^ (w < 0)) != 0) ? -longint'(m) : longint'(m);
    end
    rx = ((cs * px - sn * py + (64'sd1 << 29)) >>> 30) + xoff;
    ry = ((sn * px + cs * py + (64'sd1 << 29)) >>> 30) + yoff;
    r.comp_x = saturate(rx);
    r.comp_y = saturate(ry);
    return r;
  endfunction

  always @(posedge clk) begin
    lsmd_pkg::out_t e;
    if (rst_n && out_strobe) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result word %h", out_word);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (out_word.comp_x !== e.comp_x) begin
          $error("comp_x expected %h actual %h", e.comp_x, out_word.comp_x);
          errors++;
        end
        if (out_word.comp_y !== e.comp_y) begin
          $error("comp_y expected %h actual %h", e.comp_y, out_word.comp_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_point(logic [11:0] idx, logic [31:0] x, logic [31:0] y);
    lsmd_pkg::in_t p;
    p.point_index = idx;
    p.point_x = x;
    p.point_y = y;
    start <= 1'b1;
    in_word <= p;
    do @(posedge clk); while (busy);
    expected_points.push_back(deskew_point(p));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [lsmd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lsmd_pkg::REG_LIN_VEL:     lin_vel_q = val;
      lsmd_pkg::REG_ANG_VEL:     ang_vel_q = val;
      lsmd_pkg::REG_SCAN_PERIOD: period_q = val[lsmd_pkg::PER_W-1:0];
      lsmd_pkg::REG_POINTS:      points_q = val[lsmd_pkg::NPTS_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_motion(logic [31:0] v, logic [31:0] w, logic [31:0] per,
                            logic [31:0] n);
    drain();
    write_reg(lsmd_pkg::REG_LIN_VEL, v);
    write_reg(lsmd_pkg::REG_ANG_VEL, w);
    write_reg(lsmd_pkg::REG_SCAN_PERIOD, per);
    write_reg(lsmd_pkg::REG_POINTS, n);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(2))
      0: return $urandom();
      1: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    endcase
  endfunction

  task automatic test_pass_through;
    send_point(12'd0, 32'h7fff_ffff, 32'h8000_0000);
    send_point(12'hfff, 32'h8000_0000, 32'h7fff_ffff);
    set_motion(32'h0001_0000, 32'h0000_8000, 32'd0, 32'd1000);
    send_point(12'd500, 32'h0001_0000, 32'hffff_0000);
    drain();
    write_reg(REG_UNUSED, 32'hffff_ffff);
    send_point(12'd3, 32'h1234_5678, 32'hedcb_a988);
  endtask

  task automatic test_straight;
    set_motion(32'h7fff_ffff, 32'd0, 32'd1000000, 32'd1);
    send_point(12'hfff, 32'h7fff_ffff, 32'h0);
    send_point(12'd0, 32'h0, 32'h0);
    set_motion(32'h8000_0000, 32'd0, 32'hfffff, 32'd8191);
    send_point(12'hfff, 32'h8000_0000, 32'h8000_0000);
    send_point(12'd1, 32'h0002_0000, 32'h0);
  endtask

  task automatic test_turning;
    set_motion(32'h0002_0000, 32'h0001_0000, 32'd100000, 32'd360);
    send_point(12'd0, 32'h0005_0000, 32'h0003_0000);
    send_point(12'd359, 32'h0005_0000, 32'h0003_0000);
    send_point(12'd4000, 32'hfffb_0000, 32'h0003_0000);
    set_motion(32'h8000_0000, 32'h8000_0000, 32'd1000000, 32'd4096);
    send_point(12'hfff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(12'd2048, 32'h8000_0000, 32'h7fff_ffff);
    set_motion(32'h7fff_ffff, 32'h7fff_ffff, 32'hfffff, 32'd16);
    send_point(12'hfff, 32'h8000_0000, 32'h8000_0000);
    send_point(12'd7, 32'h0, 32'h7fff_ffff);
    set_motion(32'hfffe_0000, 32'h0000_0001, 32'd50000, 32'd1);
    send_point(12'd100, 32'h0001_0000, 32'h0001_0000);
  endtask

  task automatic test_random;
    int pcts[4] = '{0, 85, 17, 0};
    logic [31:0] v, w, per, n;
    for (int ph = 0; ph < 24; ph++) begin
      idle_pct = pcts[ph % 4];
      v = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 32'h000f_ffff) - 32'h80000;
      case ($urandom_range(3))
        0: w = 32'd0;
        1: w = $urandom();
        default: w = $urandom_range(0, 32'h0008_0000) - 32'h4_0000;
      endcase
      case ($urandom_range(7))
        0: per = 32'd0;
        1: per = $urandom_range(1000000, 32'hfffff);
        default: per = $urandom_range(1, 1000000);
      endcase
      case ($urandom_range(7))
        0: n = 32'd0;
        1: n = $urandom_range(4097, 8191);
        default: n = $urandom_range(1, 4096);
      endcase
      set_motion(v, w, per, n);
      repeat (47) begin
        send_point(($urandom_range(3) == 0 || n == 0) ? 12'($urandom()) :
                   12'($urandom_range(0, (n > 4096 ? 4096 : n) - 1)),
                   rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pass_through();
    test_straight();
    test_turning();
    test_random();
    drain();
    repeat (lsmd_pkg::LATENCY + 20) @(posedge clk);
    if (expected_points.size() != 0) begin
      $error("%0d expected results never arrived", expected_points.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/lsmd_pkg.sv
sv/lsmd_div.sv
sv/lidar_scan_motion_deskew_top.sv
sv/lsmd_chk.sv
tb/sv/lidar_scan_motion_deskew_top_tb.sv
